// ===== design/kdle_pkg.sv =====
// Shared types, constants and event code tables for the keypad debounce block.
package kdle_pkg;

   localparam int LEVEL_WIDTH     = 10;
   localparam int TIME_WIDTH      = 32;
   localparam int CFG_WIDTH       = 16;
   localparam int CODE_WIDTH      = 5;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int IX_START = 7;
   localparam int IX_FOOT  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_MS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_ON_RELEASE = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   localparam logic [CODE_WIDTH-1:0] EV_NONE        = 5'd0;
   localparam logic [CODE_WIDTH-1:0] EV_PRESS_START = 5'd1;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_UP     = 5'd2;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_DOWN   = 5'd3;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_FOCUS  = 5'd4;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_EXIT   = 5'd5;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_ADJ    = 5'd6;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_STRIP  = 5'd7;
   localparam logic [CODE_WIDTH-1:0] EV_LONG_MENU   = 5'd8;
   localparam logic [CODE_WIDTH-1:0] EV_REL_UP      = 5'd9;
   localparam logic [CODE_WIDTH-1:0] EV_REL_DOWN    = 5'd10;
   localparam logic [CODE_WIDTH-1:0] EV_REL_FOCUS   = 5'd11;
   localparam logic [CODE_WIDTH-1:0] EV_REL_EXIT    = 5'd12;
   localparam logic [CODE_WIDTH-1:0] EV_REL_ADJ     = 5'd13;
   localparam logic [CODE_WIDTH-1:0] EV_REL_STRIP   = 5'd14;
   localparam logic [CODE_WIDTH-1:0] EV_REL_MENU    = 5'd15;
   localparam logic [CODE_WIDTH-1:0] EV_REL_START   = 5'd16;
   localparam logic [CODE_WIDTH-1:0] EV_LAST        = 5'd16;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] long_press_ms;
      logic                 start_on_release;
   } cfg_type;

   function automatic logic [CODE_WIDTH-1:0] long_code(input int idx);
      logic [CODE_WIDTH-1:0] code;
      case (idx)
         0: code = EV_LONG_UP;
         1: code = EV_LONG_DOWN;
         2: code = EV_LONG_FOCUS;
         3: code = EV_LONG_EXIT;
         4: code = EV_LONG_ADJ;
         5: code = EV_LONG_STRIP;
         6: code = EV_LONG_MENU;
         default: code = EV_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [CODE_WIDTH-1:0] rel_code(input int idx);
      logic [CODE_WIDTH-1:0] code;
      case (idx)
         0: code = EV_REL_UP;
         1: code = EV_REL_DOWN;
         2: code = EV_REL_FOCUS;
         3: code = EV_REL_EXIT;
         4: code = EV_REL_ADJ;
         5: code = EV_REL_STRIP;
         6: code = EV_REL_MENU;
         7: code = EV_REL_START;
         8: code = EV_REL_START;
         9: code = EV_REL_FOCUS;
         default: code = EV_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== design/kdle_lane.sv =====
// One button lane: debounce, hold timing and the lane's event code for each transaction.
module kdle_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              level,
   input  logic [kdle_pkg::TIME_WIDTH-1:0]   now_ms,
   input  kdle_pkg::cfg_type                 cfg,
   output logic [kdle_pkg::CODE_WIDTH-1:0]   lane_code
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_PRESSED,
      MODE_LONG,
      MODE_RELEASED
   } mode_type;

   localparam logic IS_START = (LANE_INDEX == kdle_pkg::IX_START) ||
                               (LANE_INDEX == kdle_pkg::IX_FOOT);
   localparam logic [kdle_pkg::CODE_WIDTH-1:0] LONG_CODE = kdle_pkg::long_code(LANE_INDEX);
   localparam logic [kdle_pkg::CODE_WIDTH-1:0] REL_CODE  = kdle_pkg::rel_code(LANE_INDEX);

   mode_type                          mode_ff, mode_in;
   logic                              acc_level_ff, acc_level_in;
   logic [kdle_pkg::TIME_WIDTH-1:0]   change_time_ff, change_time_in;
   logic                              edge_flag_ff, edge_flag_in;
   logic                              long_rep_ff, long_rep_in;
   logic                              hold_ff, hold_in;
   logic [kdle_pkg::TIME_WIDTH-1:0]   press_time_ff, press_time_in;
   logic [kdle_pkg::CODE_WIDTH-1:0]   code_ff, code_in;
   logic [kdle_pkg::TIME_WIDTH-1:0]   since_change;
   logic [kdle_pkg::TIME_WIDTH-1:0]   since_press;

   always_comb begin
      mode_in        = mode_ff;
      acc_level_in   = acc_level_ff;
      change_time_in = change_time_ff;
      edge_flag_in   = edge_flag_ff;
      long_rep_in    = long_rep_ff;
      hold_in        = hold_ff;
      press_time_in  = press_time_ff;
      code_in        = kdle_pkg::EV_NONE;

      if ((mode_ff == MODE_PRESSED || mode_ff == MODE_LONG) && level) begin
         mode_in = MODE_RELEASED;
      end

      since_change = now_ms - change_time_ff;
      if (since_change > {{(kdle_pkg::TIME_WIDTH-kdle_pkg::CFG_WIDTH){1'b0}}, cfg.debounce_ms}
          && level != acc_level_ff) begin
         change_time_in = now_ms;
         acc_level_in   = level;
         if (!level) begin
            mode_in      = MODE_PRESSED;
            edge_flag_in = 1'b1;
            long_rep_in  = 1'b0;
         end
      end

      if (mode_in == MODE_PRESSED && !hold_ff) begin
         hold_in       = 1'b1;
         press_time_in = now_ms;
      end

      since_press = now_ms - press_time_in;
      if (hold_in &&
          since_press > {{(kdle_pkg::TIME_WIDTH-kdle_pkg::CFG_WIDTH){1'b0}}, cfg.long_press_ms})
      begin
         mode_in = MODE_LONG;
         hold_in = 1'b0;
      end

      if (IS_START && !cfg.start_on_release && edge_flag_in) begin
         edge_flag_in = 1'b0;
         code_in      = kdle_pkg::EV_PRESS_START;
      end

      case (mode_in)
         MODE_LONG: begin
            if (!long_rep_in) begin
               long_rep_in = 1'b1;
               if (LONG_CODE != kdle_pkg::EV_NONE) begin
                  code_in = LONG_CODE;
               end
            end
         end
         MODE_RELEASED: begin
            mode_in     = MODE_IDLE;
            hold_in     = 1'b0;
            long_rep_in = 1'b0;
            if (REL_CODE != kdle_pkg::EV_NONE && (!IS_START || cfg.start_on_release)) begin
               code_in = REL_CODE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         acc_level_ff   <= 1'b1;
         change_time_ff <= '0;
         edge_flag_ff   <= 1'b0;
         long_rep_ff    <= 1'b0;
         hold_ff        <= 1'b0;
         press_time_ff  <= '0;
         code_ff        <= kdle_pkg::EV_NONE;
      end else if (accept) begin
         mode_ff        <= mode_in;
         acc_level_ff   <= acc_level_in;
         change_time_ff <= change_time_in;
         edge_flag_ff   <= edge_flag_in;
         long_rep_ff    <= long_rep_in;
         hold_ff        <= hold_in;
         press_time_ff  <= press_time_in;
         code_ff        <= code_in;
      end
   end

   assign lane_code = code_ff;

   a_no_released_rest: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_RELEASED)
      else $error("lane left in released mode after a transaction");

   a_long_reported: assert property (@(posedge clock) disable iff (reset)
      accept |=> (mode_ff != MODE_LONG || long_rep_ff))
      else $error("long press mode without long press report");

   a_long_stops_hold: assert property (@(posedge clock) disable iff (reset)
      accept && mode_in == MODE_LONG && mode_ff != MODE_LONG |=> !hold_ff)
      else $error("hold timer still running after long press entry");

endmodule

// ===== design/kdle_merge.sv =====
// Merge stage: picks the highest-index lane event and holds it in the output register.
module kdle_merge #(
   parameter int BUTTON_COUNT = 10
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic [kdle_pkg::CODE_WIDTH-1:0]   lane_codes [BUTTON_COUNT],
   output logic [kdle_pkg::CODE_WIDTH-1:0]   event_code
);

   logic [kdle_pkg::CODE_WIDTH-1:0] code_ff, code_in;

   always_comb begin
      code_in = kdle_pkg::EV_NONE;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (lane_codes[i] != kdle_pkg::EV_NONE) begin
            code_in = lane_codes[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
      end
   end

   assign event_code = code_ff;

endmodule

// ===== design/keypad_debounce_longpress_events_top.sv =====
// One transaction per cycle unless rsp_stall holds, through the lane registers and the output register.
// Each button lane updates its debounce and hold state in the accepting cycle and registers its event.
// The merge stage then selects the highest-index event into the output register.
// A stalled result does not block the lanes: one more transaction may sit in the lane registers.
// Synchronous reset returns every button to idle and released and the registers to 50, 1000 and 0.
module keypad_debounce_longpress_events_top #(
   parameter int BUTTON_COUNT = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [kdle_pkg::LEVEL_WIDTH-1:0]       req_levels,
   input  logic [kdle_pkg::TIME_WIDTH-1:0]        req_now_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [kdle_pkg::CODE_WIDTH-1:0]        rsp_event_code,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kdle_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kdle_pkg::CFG_WIDTH-1:0]         csr_wdata
);

   kdle_pkg::cfg_type                 cfg_ff, cfg_in;
   logic                              lane_valid_ff, lane_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              accept;
   logic                              out_free;
   logic                              advance;
   logic [kdle_pkg::CODE_WIDTH-1:0]   lane_codes [BUTTON_COUNT];

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            kdle_pkg::CSR_DEBOUNCE_MS:      cfg_in.debounce_ms      = csr_wdata;
            kdle_pkg::CSR_LONG_PRESS_MS:    cfg_in.long_press_ms    = csr_wdata;
            kdle_pkg::CSR_START_ON_RELEASE: cfg_in.start_on_release = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign advance       = lane_valid_ff && out_free;
   assign req_stall     = lane_valid_ff && !out_free;
   assign accept        = req_valid && !req_stall;
   assign lane_valid_in = accept || (lane_valid_ff && !out_free);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= kdle_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms    <= kdle_pkg::LONG_PRESS_RESET;
         cfg_ff.start_on_release <= 1'b0;
         lane_valid_ff           <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         lane_valid_ff <= lane_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      logic level;
      if (i < kdle_pkg::LEVEL_WIDTH) begin : g_wired
         assign level = req_levels[i];
      end else begin : g_spare
         assign level = 1'b1;
      end

      kdle_lane #(
         .LANE_INDEX (i)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .level     (level),
         .now_ms    (req_now_ms),
         .cfg       (cfg_ff),
         .lane_code (lane_codes[i])
      );
   end

   kdle_merge #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_merge (
      .clock      (clock),
      .load       (advance),
      .lane_codes (lane_codes),
      .event_code (rsp_event_code)
   );

   assign rsp_valid = rsp_valid_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> lane_valid_ff)
      else $error("input stalled with empty lane stage");

   a_accept_fills_lanes: assert property (@(posedge clock) disable iff (reset)
      accept |=> lane_valid_ff)
      else $error("accepted transaction did not reach the lane stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("merged result lost on its way to the output register");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_event_code <= kdle_pkg::EV_LAST)
      else $error("event code out of range");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the keypad debounce and long-press event block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BTN_COUNT   = kdle_pkg::LEVEL_WIDTH;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 120;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [kdle_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   localparam logic [kdle_pkg::CODE_WIDTH-1:0] LONG_EVENT [BTN_COUNT] = '{
      kdle_pkg::EV_LONG_UP, kdle_pkg::EV_LONG_DOWN, kdle_pkg::EV_LONG_FOCUS,
      kdle_pkg::EV_LONG_EXIT, kdle_pkg::EV_LONG_ADJ, kdle_pkg::EV_LONG_STRIP,
      kdle_pkg::EV_LONG_MENU, kdle_pkg::EV_NONE, kdle_pkg::EV_NONE, kdle_pkg::EV_NONE};
   localparam logic [kdle_pkg::CODE_WIDTH-1:0] RELEASE_EVENT [BTN_COUNT] = '{
      kdle_pkg::EV_REL_UP, kdle_pkg::EV_REL_DOWN, kdle_pkg::EV_REL_FOCUS,
      kdle_pkg::EV_REL_EXIT, kdle_pkg::EV_REL_ADJ, kdle_pkg::EV_REL_STRIP,
      kdle_pkg::EV_REL_MENU, kdle_pkg::EV_REL_START, kdle_pkg::EV_REL_START,
      kdle_pkg::EV_REL_FOCUS};

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_PRESSED, MODE_LONG, MODE_RELEASED
   } btn_mode_type;

   typedef struct packed {
      logic [kdle_pkg::LEVEL_WIDTH-1:0] levels;
      logic [kdle_pkg::TIME_WIDTH-1:0]  now_ms;
      logic                             known;
      logic [kdle_pkg::CODE_WIDTH-1:0]  code;
   } stim_row_type;

   localparam int DIR_ROWS = 25;
   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      '{10'h3FF, 32'd0,          1'b1, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd100,        1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd1101,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd1200,       1'b0, kdle_pkg::EV_NONE},
      '{10'h37F, 32'd1300,       1'b1, kdle_pkg::EV_PRESS_START},
      '{10'h3FF, 32'd1400,       1'b0, kdle_pkg::EV_NONE},
      '{10'h2FF, 32'd1500,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd1600,       1'b0, kdle_pkg::EV_NONE},
      '{10'h1FF, 32'd1700,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd1800,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FD, 32'd1900,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd2901,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd2950,       1'b0, kdle_pkg::EV_NONE},
      '{10'h000, 32'd3100,       1'b1, kdle_pkg::EV_PRESS_START},
      '{10'h000, 32'd3101,       1'b0, kdle_pkg::EV_NONE},
      '{10'h000, 32'd4101,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd4200,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd4210,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd4250,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd4251,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd4260,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'hFFFF_FFF0,  1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'hFFFF_FFFF,  1'b0, kdle_pkg::EV_NONE},
      '{10'h3FE, 32'd1000,       1'b0, kdle_pkg::EV_NONE},
      '{10'h3FF, 32'd1100,       1'b0, kdle_pkg::EV_NONE}};

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [kdle_pkg::LEVEL_WIDTH-1:0]     req_levels = '1;
   logic [kdle_pkg::TIME_WIDTH-1:0]      req_now_ms = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [kdle_pkg::CODE_WIDTH-1:0]      rsp_event_code;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [kdle_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [kdle_pkg::CFG_WIDTH-1:0]       csr_wdata = '0;

   logic                            idle_on = 1'b1;
   int                              stall_left = 0;
   int                              fail_count = 0;
   int                              cycle_count = 0;
   logic [kdle_pkg::CODE_WIDTH-1:0] pending_events [$];

   kdle_pkg::cfg_type model_cfg;
   btn_mode_type      btn_mode      [BTN_COUNT];
   logic              btn_level     [BTN_COUNT];
   logic [31:0]       btn_change_ms [BTN_COUNT];
   logic              btn_edge      [BTN_COUNT];
   logic              btn_long_done [BTN_COUNT];
   logic              btn_holding   [BTN_COUNT];
   logic [31:0]       btn_press_ms  [BTN_COUNT];

   keypad_debounce_longpress_events_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_levels     (req_levels),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void reset_model();
      model_cfg.debounce_ms      = kdle_pkg::DEBOUNCE_RESET;
      model_cfg.long_press_ms    = kdle_pkg::LONG_PRESS_RESET;
      model_cfg.start_on_release = 1'b0;
      for (int i = 0; i < BTN_COUNT; i++) begin
         btn_mode[i]      = MODE_IDLE;
         btn_level[i]     = 1'b1;
         btn_change_ms[i] = '0;
         btn_edge[i]      = 1'b0;
         btn_long_done[i] = 1'b0;
         btn_holding[i]   = 1'b0;
         btn_press_ms[i]  = '0;
      end
   endfunction

   function automatic void apply_csr(input logic [kdle_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [kdle_pkg::CFG_WIDTH-1:0] data);
      case (idx)
         kdle_pkg::CSR_DEBOUNCE_MS:      model_cfg.debounce_ms = data;
         kdle_pkg::CSR_LONG_PRESS_MS:    model_cfg.long_press_ms = data;
         kdle_pkg::CSR_START_ON_RELEASE: model_cfg.start_on_release = data[0];
         default: ;
      endcase
   endfunction

   function automatic logic [kdle_pkg::CODE_WIDTH-1:0] predict_event(
      input logic [kdle_pkg::LEVEL_WIDTH-1:0] lv,
      input logic [kdle_pkg::TIME_WIDTH-1:0]  now);
      logic [kdle_pkg::CODE_WIDTH-1:0] ev;
      logic [31:0]                     since;
      logic                            is_start;
      ev = kdle_pkg::EV_NONE;
      for (int i = 0; i < BTN_COUNT; i++) begin
         if ((btn_mode[i] == MODE_PRESSED || btn_mode[i] == MODE_LONG) && lv[i])
            btn_mode[i] = MODE_RELEASED;
         since = now - btn_change_ms[i];
         if (since > 32'(model_cfg.debounce_ms) && lv[i] != btn_level[i]) begin
            btn_change_ms[i] = now;
            btn_level[i]     = lv[i];
            if (!lv[i]) begin
               btn_mode[i]      = MODE_PRESSED;
               btn_edge[i]      = 1'b1;
               btn_long_done[i] = 1'b0;
            end
         end
         if (btn_mode[i] == MODE_PRESSED && !btn_holding[i]) begin
            btn_holding[i]  = 1'b1;
            btn_press_ms[i] = now;
         end
         since = now - btn_press_ms[i];
         if (btn_holding[i] && since > 32'(model_cfg.long_press_ms)) begin
            btn_mode[i]    = MODE_LONG;
            btn_holding[i] = 1'b0;
         end
      end
      for (int i = 0; i < BTN_COUNT; i++) begin
         is_start = (i == kdle_pkg::IX_START || i == kdle_pkg::IX_FOOT);
         if (!model_cfg.start_on_release && is_start && btn_edge[i]) begin
            btn_edge[i] = 1'b0;
            ev = kdle_pkg::EV_PRESS_START;
         end
         if (btn_mode[i] == MODE_LONG) begin
            if (!btn_long_done[i]) begin
               btn_long_done[i] = 1'b1;
               if (LONG_EVENT[i] != kdle_pkg::EV_NONE) ev = LONG_EVENT[i];
            end
         end else if (btn_mode[i] == MODE_RELEASED) begin
            btn_mode[i]      = MODE_IDLE;
            btn_holding[i]   = 1'b0;
            btn_long_done[i] = 1'b0;
            if (!is_start || model_cfg.start_on_release) ev = RELEASE_EVENT[i];
         end
      end
      return ev;
   endfunction

   task automatic send_item(input logic [kdle_pkg::LEVEL_WIDTH-1:0] lv,
                            input logic [kdle_pkg::TIME_WIDTH-1:0] t,
                            input logic known,
                            input logic [kdle_pkg::CODE_WIDTH-1:0] known_code);
      logic [kdle_pkg::CODE_WIDTH-1:0] ev;
      req_valid  <= 1'b1;
      req_levels <= lv;
      req_now_ms <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ev = predict_event(lv, t);
      pending_events.push_back(known ? known_code : ev);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [kdle_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [kdle_pkg::CFG_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 9) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("event_code: expected none pending, actual %0d", rsp_event_code);
            fail_count++;
         end else if (rsp_event_code !== pending_events[0]) begin
            $error("event_code: expected %0d, actual %0d", pending_events[0], rsp_event_code);
            fail_count++;
            void'(pending_events.pop_front());
         end else begin
            void'(pending_events.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** keypad_debounce_longpress_events_top: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [kdle_pkg::CFG_WIDTH-1:0]   dbc;
      logic [kdle_pkg::CFG_WIDTH-1:0]   lp;
      logic                             sor;
      logic [kdle_pkg::LEVEL_WIDTH-1:0] cur_lv;
      logic [kdle_pkg::TIME_WIDTH-1:0]  cur_ms;
      logic [kdle_pkg::LEVEL_WIDTH-1:0] lv;
      logic [kdle_pkg::TIME_WIDTH-1:0]  t;
      int                               span;
      int                               roll;
      reset_model();
      cur_lv = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++)
         send_item(DIRECTED[r].levels, DIRECTED[r].now_ms, DIRECTED[r].known, DIRECTED[r].code);
      req_valid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         while (pending_events.size() != 0) @(posedge clock);
         case (ph)
            0: begin
               dbc = '0;
               lp  = '0;
               sor = 1'b1;
            end
            1: begin
               dbc = '1;
               lp  = '1;
               sor = 1'b0;
            end
            2: begin
               dbc = 16'd3;
               lp  = 16'd30;
               sor = 1'b1;
            end
            default: begin
               dbc = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 400));
               lp  = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
               sor = 1'($urandom_range(0, 1));
            end
         endcase
         write_csr(kdle_pkg::CSR_DEBOUNCE_MS, dbc);
         write_csr(CSR_UNUSED, 16'($urandom()));
         write_csr(kdle_pkg::CSR_LONG_PRESS_MS, lp);
         write_csr(kdle_pkg::CSR_START_ON_RELEASE, {15'($urandom()), sor});
         csr_valid <= 1'b0;
         idle_on   <= (ph != PHASES - 1);
         span   = (int'(dbc) + int'(lp)) / 5 + 8;
         cur_ms = $urandom();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               lv     = BTN_COUNT'($urandom());
               t      = (roll < 4) ? $urandom() : cur_ms + $urandom_range(0, span);
               cur_ms = t;
            end else begin
               if (roll < 35)
                  cur_lv[$urandom_range(0, BTN_COUNT - 1)] ^= 1'b1;
               else if (roll < 38)
                  cur_lv = '1;
               cur_ms = cur_ms + $urandom_range(0, span);
               lv     = cur_lv;
               t      = cur_ms;
            end
            send_item(lv, t, 1'b0, kdle_pkg::EV_NONE);
         end
         req_valid <= 1'b0;
      end

      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("** keypad_debounce_longpress_events_top: PASSED **");
      else
         $display("** keypad_debounce_longpress_events_top: FAILED **");
      $finish;
   end

endmodule
